### sv/lpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the IPv4 longest prefix match block
// Field widths, item kind codes and the command format handed from the front
// part to the lookup engine through the command queue.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Field widths fixed by the item format
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 5;
  localparam int PORT_W = 2;

  // Default table geometry
  localparam int DEF_ENTRIES = 32;
  localparam int DEF_PORTS   = 4;

  // Depth of the command queue between front and engine
  localparam int QUEUE_DEPTH = 2;

  // Item kind codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Classified command; key carries the route prefix or the lookup address
  typedef struct packed {
    logic              lookup;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
    logic              enable;
  } cmd_t;

endpackage

### sv/ipv4_longest_prefix_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match: IPv4 route table with longest prefix lookup
// Write items store routes in slots; lookup items return the valid route with
// the largest mask that covers the address, lowest slot on equal masks.
//
//   channel  ports                          direction  item
//   in       in_valid / in_stall, fields    input      route write or lookup
//   out      out_valid / out_stall, fields  output     lookup result
//
// A write is stored straight from the idle state; a lookup walks every slot
// through the registered route memory read port, one slot a cycle. After reset
// the valid marks are cleared in a pass over every slot, during which
// in_stall is high. Two queued commands plus a holding stage let items enter
// while a scan runs, and a finished result waits in the output register
// without blocking the next scan from being queued.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match #(
  parameter int ENTRIES = lpm_pkg::DEF_ENTRIES,
  parameter int PORTS   = lpm_pkg::DEF_PORTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [lpm_pkg::SLOT_W-1:0] in_slot,
  input  logic [lpm_pkg::ADDR_W-1:0] in_route_prefix,
  input  logic [lpm_pkg::ADDR_W-1:0] in_route_mask,
  input  logic [lpm_pkg::ADDR_W-1:0] in_route_gateway,
  input  logic [lpm_pkg::PORT_W-1:0] in_route_port,
  input  logic                      in_route_enable,
  input  logic [lpm_pkg::ADDR_W-1:0] in_lookup_addr,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic [lpm_pkg::SLOT_W-1:0] out_match_slot,
  output logic [lpm_pkg::ADDR_W-1:0] out_match_gateway,
  output logic [lpm_pkg::PORT_W-1:0] out_match_port,
  output logic [lpm_pkg::ADDR_W-1:0] out_match_mask
);

  logic          clear_busy;
  logic          push;
  lpm_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  lpm_pkg::cmd_t q_cmd;
  logic          q_empty;

  // Accept and classify items
  lpm_front #(
    .ENTRIES (ENTRIES),
    .PORTS   (PORTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_route_prefix  (in_route_prefix),
    .in_route_mask    (in_route_mask),
    .in_route_gateway (in_route_gateway),
    .in_route_port    (in_route_port),
    .in_route_enable  (in_route_enable),
    .in_lookup_addr   (in_lookup_addr),
    .clear_busy       (clear_busy),
    .push             (push),
    .push_cmd         (push_cmd),
    .q_full           (q_full)
  );

  // Queue commands for the engine
  lpm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  // Execute writes and scans
  lpm_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_cmd             (q_cmd),
    .pop               (pop),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_match_slot    (out_match_slot),
    .out_match_gateway (out_match_gateway),
    .out_match_port    (out_match_port),
    .out_match_mask    (out_match_mask)
  );

endmodule

### sv/lpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_front: input stage of the route table
// Accepts items, drops writes to slots or ports outside the table, packs the
// rest into commands and hands them to the command queue.
// ----------------------------------------------------------------------------
module lpm_front #(
  parameter int ENTRIES = lpm_pkg::DEF_ENTRIES,
  parameter int PORTS   = lpm_pkg::DEF_PORTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [lpm_pkg::SLOT_W-1:0] in_slot,
  input  logic [lpm_pkg::ADDR_W-1:0] in_route_prefix,
  input  logic [lpm_pkg::ADDR_W-1:0] in_route_mask,
  input  logic [lpm_pkg::ADDR_W-1:0] in_route_gateway,
  input  logic [lpm_pkg::PORT_W-1:0] in_route_port,
  input  logic                      in_route_enable,
  input  logic [lpm_pkg::ADDR_W-1:0] in_lookup_addr,
  input  logic                      clear_busy,
  output logic                      push,
  output lpm_pkg::cmd_t             push_cmd,
  input  logic                      q_full
);

  logic          hold_vld_r;
  logic          hold_vld_nxt;
  lpm_pkg::cmd_t hold_cmd_r;
  lpm_pkg::cmd_t cmd_new;
  logic          accept;
  logic          keep;

  // Hand the held command on whenever the queue has room
  assign push     = hold_vld_r & ~q_full;
  assign push_cmd = hold_cmd_r;

  // Take no item during the table clear or while the holding stage is stuck
  assign in_stall = clear_busy | (hold_vld_r & q_full);
  assign accept   = in_valid & ~in_stall;

  // Classify: lookups always go on, writes only for slots and ports that exist
  assign keep = (in_kind == lpm_pkg::KIND_LOOKUP) ||
                ((32'(in_slot) < 32'(ENTRIES)) && (32'(in_route_port) < 32'(PORTS)));

  always_comb begin
    cmd_new.lookup  = (in_kind == lpm_pkg::KIND_LOOKUP);
    cmd_new.slot    = in_slot;
    cmd_new.key     = (in_kind == lpm_pkg::KIND_LOOKUP) ? in_lookup_addr : in_route_prefix;
    cmd_new.mask    = in_route_mask;
    cmd_new.gateway = in_route_gateway;
    cmd_new.port    = in_route_port;
    cmd_new.enable  = in_route_enable;
  end

  // Fill or drain the holding stage
  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (accept && keep) begin
      hold_vld_nxt = 1'b1;
    end else if (push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      hold_cmd_r <= cmd_new;
    end
  end

endmodule

### sv/lpm_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_cmd_fifo: command queue between front and lookup engine
// Small register queue that lets the front keep taking items while the
// engine scans the table.
// ----------------------------------------------------------------------------
module lpm_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lpm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output lpm_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int PTR_W = (lpm_pkg::QUEUE_DEPTH > 1) ? $clog2(lpm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lpm_pkg::QUEUE_DEPTH + 1);

  lpm_pkg::cmd_t    slots_r [lpm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full    = (count_r == CNT_W'(lpm_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = slots_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue read while empty");

endmodule

### sv/lpm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_engine: route memory and longest prefix scan
// Holds the route table in memories, clears the valid marks after reset,
// executes writes and scans every slot, one a cycle, for lookups.
// ----------------------------------------------------------------------------
module lpm_engine #(
  parameter int ENTRIES = lpm_pkg::DEF_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  lpm_pkg::cmd_t             q_cmd,
  output logic                      pop,
  output logic                      clear_busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic [lpm_pkg::SLOT_W-1:0] out_match_slot,
  output logic [lpm_pkg::ADDR_W-1:0] out_match_gateway,
  output logic [lpm_pkg::PORT_W-1:0] out_match_port,
  output logic [lpm_pkg::ADDR_W-1:0] out_match_mask
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Route memories
  logic [lpm_pkg::ADDR_W-1:0] prefix_mem  [ENTRIES];
  logic [lpm_pkg::ADDR_W-1:0] mask_mem    [ENTRIES];
  logic [lpm_pkg::ADDR_W-1:0] gateway_mem [ENTRIES];
  logic [lpm_pkg::PORT_W-1:0] port_mem    [ENTRIES];
  logic                       valid_mem   [ENTRIES];

  logic [2:0]                 state_r;
  logic [2:0]                 state_nxt;
  logic [IDX_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           cnt_nxt;
  logic                       last;
  logic                       mem_we;
  logic                       valid_we;
  logic [IDX_W-1:0]           wr_idx;
  logic                       wr_valid;
  logic                       scan_rd;
  logic                       load_out;
  logic                       out_free;

  // Registered read side
  logic                       rd_vld_r;
  logic [IDX_W-1:0]           rd_idx_r;
  logic [lpm_pkg::ADDR_W-1:0] rd_prefix_r;
  logic [lpm_pkg::ADDR_W-1:0] rd_mask_r;
  logic [lpm_pkg::ADDR_W-1:0] rd_gateway_r;
  logic [lpm_pkg::PORT_W-1:0] rd_port_r;
  logic                       rd_valid_r;

  // Running best match
  logic [lpm_pkg::ADDR_W-1:0] addr_r;
  logic                       found_r;
  logic [IDX_W-1:0]           best_idx_r;
  logic [lpm_pkg::ADDR_W-1:0] best_mask_r;
  logic [lpm_pkg::ADDR_W-1:0] best_gateway_r;
  logic [lpm_pkg::PORT_W-1:0] best_port_r;
  logic                       match;
  logic                       better;

  // Result register
  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [lpm_pkg::SLOT_W-1:0] out_match_slot_r;
  logic [lpm_pkg::ADDR_W-1:0] out_match_gateway_r;
  logic [lpm_pkg::PORT_W-1:0] out_match_port_r;
  logic [lpm_pkg::ADDR_W-1:0] out_match_mask_r;

  assign last       = (cnt_r == IDX_W'(ENTRIES - 1));
  assign out_free   = ~out_valid_r | ~out_stall;
  assign clear_busy = (state_r == ST_CLEAR);

  // Sequence clear, writes and table scans
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    valid_we  = 1'b0;
    wr_idx    = cnt_r;
    wr_valid  = 1'b0;
    scan_rd   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        valid_we = 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_cmd.lookup) begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
          end else begin
            mem_we   = 1'b1;
            valid_we = 1'b1;
            wr_idx   = IDX_W'(q_cmd.slot);
            wr_valid = q_cmd.enable;
          end
        end
      end
      ST_SCAN: begin
        scan_rd = 1'b1;
        if (last) begin
          state_nxt = ST_LAST;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_LAST: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Write one slot, read the slot under the scan counter
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_mem[wr_idx]  <= q_cmd.key;
      mask_mem[wr_idx]    <= q_cmd.mask;
      gateway_mem[wr_idx] <= q_cmd.gateway;
      port_mem[wr_idx]    <= q_cmd.port;
    end
    if (valid_we) begin
      valid_mem[wr_idx] <= wr_valid;
    end
    rd_prefix_r  <= prefix_mem[cnt_r];
    rd_mask_r    <= mask_mem[cnt_r];
    rd_gateway_r <= gateway_mem[cnt_r];
    rd_port_r    <= port_mem[cnt_r];
    rd_valid_r   <= valid_mem[cnt_r];
    rd_idx_r     <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_rd;
    end
  end

  // Compare the slot just read; keep the larger mask, earlier slot on a tie
  assign match  = rd_valid_r && ((addr_r & rd_mask_r) == (rd_prefix_r & rd_mask_r));
  assign better = match && (!found_r || (rd_mask_r > best_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (pop && q_cmd.lookup) begin
      found_r <= 1'b0;
    end else if (rd_vld_r && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.lookup) begin
      addr_r <= q_cmd.key;
    end
    if (rd_vld_r && better) begin
      best_idx_r     <= rd_idx_r;
      best_mask_r    <= rd_mask_r;
      best_gateway_r <= rd_gateway_r;
      best_port_r    <= rd_port_r;
    end
  end

  // Hold the result until taken; zero every field on a miss
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r           <= found_r;
      out_match_slot_r    <= found_r ? lpm_pkg::SLOT_W'(best_idx_r) : '0;
      out_match_gateway_r <= found_r ? best_gateway_r : '0;
      out_match_port_r    <= found_r ? best_port_r : '0;
      out_match_mask_r    <= found_r ? best_mask_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_match_slot    = out_match_slot_r;
  assign out_match_gateway = out_match_gateway_r;
  assign out_match_port    = out_match_port_r;
  assign out_match_mask    = out_match_mask_r;

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_match_slot_r == '0 && out_match_gateway_r == '0 &&
                                     out_match_port_r == '0 && out_match_mask_r == '0))
    else $error("miss result carries nonzero fields");

  a_no_pop_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !pop)
    else $error("command taken during table clear");

  a_hit_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (32'(out_match_slot_r) < 32'(ENTRIES)))
    else $error("hit reports a slot outside the table");

endmodule
